// ===== hw/rtl/bvm_pkg.sv =====
`default_nettype none

package bvm_pkg;

  // Field widths.
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned VOLT_W     = 16;
  localparam int unsigned SCALED_W   = 9;
  localparam int unsigned CELLS_W    = 4;
  localparam int unsigned CELLV_W    = 6;
  localparam int unsigned LEVEL_W    = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Operand widths of the shared divider and the sample-by-scale product.
  localparam int unsigned PROD_W     = 20;
  localparam int unsigned DIV_NUM_W  = 29;
  localparam int unsigned DIV_DEN_W  = 20;

  // Conversion constants.
  localparam int unsigned VOLT_K        = 343;
  localparam int unsigned ADC_FULL      = 4095;
  localparam int unsigned ROUND_ADD     = ADC_FULL * 50;
  localparam int unsigned SCALED_K      = 330;
  localparam int unsigned PRESENT_LEVEL = 10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_SCALE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_VALUE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_MULTIPLIER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CELL_VOLTAGE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CELL_VOLTAGE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_CELL_VOLTAGE  = 3'd5;

  // Configuration reset values.
  localparam logic [CFG_DATA_W-1:0] RST_VOLTAGE_SCALE      = 8'd110;
  localparam logic [CFG_DATA_W-1:0] RST_DIVIDER_VALUE      = 8'd10;
  localparam logic [CFG_DATA_W-1:0] RST_DIVIDER_MULTIPLIER = 8'd1;
  localparam logic [CELLV_W-1:0]    RST_MAX_CELL_VOLTAGE   = 6'd43;
  localparam logic [CELLV_W-1:0]    RST_MIN_CELL_VOLTAGE   = 6'd33;
  localparam logic [CELLV_W-1:0]    RST_WARN_CELL_VOLTAGE  = 6'd35;
  localparam logic [CELLS_W-1:0]    RST_CELL_COUNT         = 4'd1;

  typedef enum logic [1:0] {
    MODE_OK     = 2'd0,
    MODE_WARN   = 2'd1,
    MODE_CRIT   = 2'd2,
    MODE_ABSENT = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    BEEP_NONE = 2'd0,
    BEEP_LOW  = 2'd1,
    BEEP_CRIT = 2'd2
  } beep_e;

  // Which division the shared divider is running.
  typedef enum logic [2:0] {
    OP_FILT_STEP1,
    OP_FILT_STEP2,
    OP_RAW_STEP1,
    OP_RAW_STEP2,
    OP_CELLS
  } div_op_e;

  typedef struct packed {
    logic    mul;
    logic    mul_raw;
    logic    start;
    div_op_e op;
    logic    wb;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic need_cells;
    logic out_busy;
  } sts_t;

  function automatic logic [VOLT_W-1:0] sat_volt(input logic [DIV_NUM_W-1:0] q);
    logic [VOLT_W-1:0] r;
    r = (|q[DIV_NUM_W-1:VOLT_W]) ? '1 : q[VOLT_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bvm_in_if.sv =====
`default_nettype none

interface bvm_in_if;
  logic                         valid;
  logic                         ready;
  logic [bvm_pkg::SAMPLE_W-1:0] filtered_sample;
  logic [bvm_pkg::SAMPLE_W-1:0] raw_sample;

  modport source (output valid, output filtered_sample, output raw_sample, input ready);
  modport sink (input valid, input filtered_sample, input raw_sample, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bvm_out_if.sv =====
`default_nettype none

interface bvm_out_if;
  logic                         valid;
  logic                         ready;
  logic [bvm_pkg::VOLT_W-1:0]   voltage;
  logic [bvm_pkg::SCALED_W-1:0] scaled_value;
  logic [1:0]                   battery_status;
  logic [1:0]                   beep_request;
  logic                         failsafe_request;
  logic                         arming_release;
  logic [bvm_pkg::CELLS_W-1:0]  cells;

  modport source (
    output valid, output voltage, output scaled_value, output battery_status,
    output beep_request, output failsafe_request, output arming_release, output cells,
    input ready
  );
  modport sink (
    input valid, input voltage, input scaled_value, input battery_status,
    input beep_request, input failsafe_request, input arming_release, input cells,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/bvm_cfg_if.sv =====
`default_nettype none

interface bvm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bvm_pkg::CFG_IDX_W-1:0]  index;
  logic [bvm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/battery_voltage_monitor.sv =====
// Each input transfer yields one result, after two divisions of the filtered sample;
// when the item connects the battery, the cell count is detected from the raw sample
// (three more divisions). One item at a time: the input is not ready again until
// its result is written. All divisions share one divider that retires a bit per cycle.
// Reset (rst_ni, asynchronous, active low): registers at their defaults, battery not
// present, cell count 1, both levels 0, result register empty.
`default_nettype none

module battery_voltage_monitor #(
  parameter int unsigned MAX_CELLS = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bvm_in_if.sink     in_i,
  bvm_cfg_if.sink    cfg_i,
  bvm_out_if.source  out_o
);

  logic          in_fire;
  logic          in_ready;
  logic          cfg_fire;
  bvm_pkg::cmd_t cmd;
  bvm_pkg::sts_t sts;

  assign in_fire     = in_i.valid && in_ready;
  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  bvm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .in_ready_o(in_ready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  bvm_dp #(
    .MAX_CELLS(MAX_CELLS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_fire_i         (in_fire),
    .filtered_sample_i (in_i.filtered_sample),
    .raw_sample_i      (in_i.raw_sample),
    .cfg_fire_i        (cfg_fire),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .voltage_o         (out_o.voltage),
    .scaled_value_o    (out_o.scaled_value),
    .battery_status_o  (out_o.battery_status),
    .beep_request_o    (out_o.beep_request),
    .failsafe_request_o(out_o.failsafe_request),
    .arming_release_o  (out_o.arming_release),
    .cells_o           (out_o.cells)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/bvm_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. A zero divisor gives all ones.
module bvm_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [bvm_pkg::DIV_NUM_W-1:0]   num_i,
  input  wire logic [bvm_pkg::DIV_DEN_W-1:0]   den_i,
  output logic                                 done_o,
  output logic [bvm_pkg::DIV_NUM_W-1:0]        quot_o
);

  localparam int unsigned NW    = bvm_pkg::DIV_NUM_W;
  localparam int unsigned DW    = bvm_pkg::DIV_DEN_W;
  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem_q;
  logic [NW-1:0]    quo_q;
  logic [DW-1:0]    den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             qbit;

  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    diff  = trial - {1'b0, den_q};
    qbit  = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= qbit ? diff[DW-1:0] : trial[DW-1:0];
      quo_q <= {quo_q[NW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bvm_dp.sv =====
`default_nettype none

module bvm_dp #(
  parameter int unsigned MAX_CELLS = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_fire_i,
  input  wire logic [bvm_pkg::SAMPLE_W-1:0]     filtered_sample_i,
  input  wire logic [bvm_pkg::SAMPLE_W-1:0]     raw_sample_i,
  input  wire logic                             cfg_fire_i,
  input  wire logic [bvm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [bvm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire bvm_pkg::cmd_t                    cmd_i,
  output bvm_pkg::sts_t                         sts_o,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output logic [bvm_pkg::VOLT_W-1:0]            voltage_o,
  output logic [bvm_pkg::SCALED_W-1:0]          scaled_value_o,
  output logic [1:0]                            battery_status_o,
  output logic [1:0]                            beep_request_o,
  output logic                                  failsafe_request_o,
  output logic                                  arming_release_o,
  output logic [bvm_pkg::CELLS_W-1:0]           cells_o
);

  localparam int unsigned SW  = bvm_pkg::SAMPLE_W;
  localparam int unsigned VW  = bvm_pkg::VOLT_W;
  localparam int unsigned LW  = bvm_pkg::LEVEL_W;
  localparam int unsigned CW  = bvm_pkg::CELLS_W;
  localparam int unsigned NW  = bvm_pkg::DIV_NUM_W;
  localparam int unsigned DW  = bvm_pkg::DIV_DEN_W;
  localparam int unsigned PW  = bvm_pkg::PROD_W;
  localparam int unsigned XW  = 21;
  localparam int unsigned SCW = bvm_pkg::SCALED_W;

  // Configuration registers.
  logic [bvm_pkg::CFG_DATA_W-1:0] vscale_q, divval_q, divmul_q;
  logic [bvm_pkg::CELLV_W-1:0]    maxcell_q, mincell_q, warncell_q;

  // Working registers.
  logic [SW-1:0]  filt_q, raw_q;
  logic [PW-1:0]  prod_q;
  logic [NW-1:0]  qtmp_q;
  logic [VW-1:0]  volt_q, rvolt_q, cquot_q;

  // Monitor state.
  bvm_pkg::mode_e mode_q;
  logic [CW-1:0]  cells_q;
  logic [LW-1:0]  warn_lvl_q, crit_lvl_q;

  // Result register.
  logic           out_valid_q;
  logic [VW-1:0]  out_volt_q;
  logic [SCW-1:0] out_scaled_q;
  bvm_pkg::mode_e out_mode_q;
  bvm_pkg::beep_e out_beep_q;
  logic           out_fs_q, out_arm_q;
  logic [CW-1:0]  out_cells_q;

  logic           div_done;
  logic [NW-1:0]  div_quot;
  logic [NW-1:0]  div_num;
  logic [DW-1:0]  div_den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vscale_q   <= bvm_pkg::RST_VOLTAGE_SCALE;
      divval_q   <= bvm_pkg::RST_DIVIDER_VALUE;
      divmul_q   <= bvm_pkg::RST_DIVIDER_MULTIPLIER;
      maxcell_q  <= bvm_pkg::RST_MAX_CELL_VOLTAGE;
      mincell_q  <= bvm_pkg::RST_MIN_CELL_VOLTAGE;
      warncell_q <= bvm_pkg::RST_WARN_CELL_VOLTAGE;
    end else if (cfg_fire_i) begin
      unique case (cfg_index_i)
        bvm_pkg::REG_VOLTAGE_SCALE:      vscale_q   <= cfg_data_i;
        bvm_pkg::REG_DIVIDER_VALUE:      divval_q   <= cfg_data_i;
        bvm_pkg::REG_DIVIDER_MULTIPLIER: divmul_q   <= cfg_data_i;
        bvm_pkg::REG_MAX_CELL_VOLTAGE:   maxcell_q  <= cfg_data_i[bvm_pkg::CELLV_W-1:0];
        bvm_pkg::REG_MIN_CELL_VOLTAGE:   mincell_q  <= cfg_data_i[bvm_pkg::CELLV_W-1:0];
        bvm_pkg::REG_WARN_CELL_VOLTAGE:  warncell_q <= cfg_data_i[bvm_pkg::CELLV_W-1:0];
        default: ;
      endcase
    end
  end

  // Divider operands. The first step divides by 4095 * divider_value, the
  // second by divider_multiplier; the cell count divides the raw voltage.
  always_comb begin
    div_num = '0;
    div_den = '0;
    unique case (cmd_i.op)
      bvm_pkg::OP_FILT_STEP1, bvm_pkg::OP_RAW_STEP1: begin
        div_num = NW'(prod_q) * NW'(bvm_pkg::VOLT_K) + NW'(bvm_pkg::ROUND_ADD);
        div_den = {divval_q, 12'd0} - DW'(divval_q);
      end
      bvm_pkg::OP_FILT_STEP2, bvm_pkg::OP_RAW_STEP2: begin
        div_num = qtmp_q;
        div_den = DW'(divmul_q);
      end
      bvm_pkg::OP_CELLS: begin
        div_num = NW'(rvolt_q);
        div_den = DW'(maxcell_q);
      end
      default: ;
    endcase
  end

  bvm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      filt_q <= filtered_sample_i;
      raw_q  <= raw_sample_i;
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(cmd_i.mul_raw ? raw_q : filt_q) * PW'(vscale_q);
    end
    if (div_done) begin
      unique case (cmd_i.op)
        bvm_pkg::OP_FILT_STEP1, bvm_pkg::OP_RAW_STEP1: qtmp_q <= div_quot;
        bvm_pkg::OP_FILT_STEP2: volt_q  <= bvm_pkg::sat_volt(div_quot);
        bvm_pkg::OP_RAW_STEP2:  rvolt_q <= bvm_pkg::sat_volt(div_quot);
        bvm_pkg::OP_CELLS:      cquot_q <= bvm_pkg::sat_volt(div_quot);
        default: ;
      endcase
    end
  end

  // Presence and cell detection.
  logic           present_hit, absent, connect, disconnect;
  logic [CW-1:0]  cells_det, cells_d;
  logic [LW-1:0]  warn_lvl_d, crit_lvl_d;
  bvm_pkg::mode_e mode_mid, mode_d;
  bvm_pkg::beep_e beep_d;
  logic           fs_d, arm_d;
  logic           below_warn, above_warn, below_crit, above_crit;

  // 0..330 value: x / 4095 = x/4096 plus a one-step correction.
  logic [XW-1:0]  scaled_x;
  logic [SCW-1:0] scaled_q0, scaled_d;
  logic [12:0]    scaled_r;

  always_comb begin
    present_hit = volt_q > VW'(bvm_pkg::PRESENT_LEVEL);
    absent      = (mode_q == bvm_pkg::MODE_ABSENT);
    connect     = absent && present_hit;
    disconnect  = !absent && !present_hit;

    if (cquot_q >= VW'(MAX_CELLS)) begin
      cells_det = CW'(MAX_CELLS);
    end else begin
      cells_det = cquot_q[CW-1:0] + 1'b1;
    end

    mode_mid   = mode_q;
    cells_d    = cells_q;
    warn_lvl_d = warn_lvl_q;
    crit_lvl_d = crit_lvl_q;
    if (connect) begin
      mode_mid   = bvm_pkg::MODE_OK;
      cells_d    = cells_det;
      warn_lvl_d = LW'(cells_det) * LW'(warncell_q);
      crit_lvl_d = LW'(cells_det) * LW'(mincell_q);
    end else if (disconnect) begin
      mode_mid   = bvm_pkg::MODE_ABSENT;
      cells_d    = '0;
      warn_lvl_d = '0;
      crit_lvl_d = '0;
    end

    // A level of zero never trips: the voltage cannot drop below it.
    below_warn = volt_q < VW'(warn_lvl_d);
    above_warn = volt_q > (VW'(warn_lvl_d) + 1'b1);
    below_crit = volt_q < VW'(crit_lvl_d);
    above_crit = volt_q > (VW'(crit_lvl_d) + 1'b1);

    mode_d = mode_mid;
    beep_d = bvm_pkg::BEEP_NONE;
    fs_d   = 1'b0;
    arm_d  = 1'b0;
    unique case (mode_mid)
      bvm_pkg::MODE_OK: begin
        if (below_warn) begin
          mode_d = bvm_pkg::MODE_WARN;
          beep_d = bvm_pkg::BEEP_LOW;
        end
      end
      bvm_pkg::MODE_WARN: begin
        arm_d = 1'b1;
        fs_d  = 1'b1;
        priority if (below_crit) begin
          mode_d = bvm_pkg::MODE_CRIT;
          beep_d = bvm_pkg::BEEP_CRIT;
        end else if (above_warn) begin
          mode_d = bvm_pkg::MODE_OK;
        end else begin
          beep_d = bvm_pkg::BEEP_LOW;
        end
      end
      bvm_pkg::MODE_CRIT: begin
        fs_d = 1'b1;
        if (above_crit) begin
          mode_d = bvm_pkg::MODE_WARN;
          beep_d = bvm_pkg::BEEP_LOW;
        end else begin
          beep_d = bvm_pkg::BEEP_CRIT;
        end
      end
      bvm_pkg::MODE_ABSENT: ;
      default: ;
    endcase

    scaled_x  = XW'(filt_q) * XW'(bvm_pkg::SCALED_K);
    scaled_q0 = scaled_x[XW-1:12];
    scaled_r  = 13'(scaled_x[11:0]) + 13'(scaled_q0);
    scaled_d  = scaled_q0 + SCW'(scaled_r >= 13'(bvm_pkg::ADC_FULL));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= bvm_pkg::MODE_ABSENT;
      cells_q     <= bvm_pkg::RST_CELL_COUNT;
      warn_lvl_q  <= '0;
      crit_lvl_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wb) begin
        mode_q      <= mode_d;
        cells_q     <= cells_d;
        warn_lvl_q  <= warn_lvl_d;
        crit_lvl_q  <= crit_lvl_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb) begin
      out_volt_q   <= volt_q;
      out_scaled_q <= scaled_d;
      out_mode_q   <= mode_d;
      out_beep_q   <= beep_d;
      out_fs_q     <= fs_d;
      out_arm_q    <= arm_d;
      out_cells_q  <= cells_d;
    end
  end

  always_comb begin
    sts_o.div_done   = div_done;
    sts_o.need_cells = connect;
    sts_o.out_busy   = out_valid_q;
  end

  assign out_valid_o        = out_valid_q;
  assign voltage_o          = out_volt_q;
  assign scaled_value_o     = out_scaled_q;
  assign battery_status_o   = out_mode_q;
  assign beep_request_o     = out_beep_q;
  assign failsafe_request_o = out_fs_q;
  assign arming_release_o   = out_arm_q;
  assign cells_o            = out_cells_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bvm_ctrl.sv =====
`default_nettype none

module bvm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_fire_i,
  output logic               in_ready_o,
  output bvm_pkg::cmd_t      cmd_o,
  input  wire bvm_pkg::sts_t sts_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_FILT,
    ST_FILT1,
    ST_FILT2,
    ST_CHECK,
    ST_MUL_RAW,
    ST_RAW1,
    ST_RAW2,
    ST_CELLS,
    ST_WRITE
  } state_e;

  state_e        state_q;
  bvm_pkg::cmd_t cmd_q;
  logic          in_ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_ready_q <= 1'b1;
      cmd_q      <= '{mul: 1'b0, mul_raw: 1'b0, start: 1'b0,
                      op: bvm_pkg::OP_FILT_STEP1, wb: 1'b0};
    end else begin
      cmd_q.mul   <= 1'b0;
      cmd_q.start <= 1'b0;
      cmd_q.wb    <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire_i) begin
            in_ready_q    <= 1'b0;
            cmd_q.mul     <= 1'b1;
            cmd_q.mul_raw <= 1'b0;
            state_q       <= ST_MUL_FILT;
          end
        end
        ST_MUL_FILT: begin
          cmd_q.start <= 1'b1;
          cmd_q.op    <= bvm_pkg::OP_FILT_STEP1;
          state_q     <= ST_FILT1;
        end
        ST_FILT1: begin
          if (sts_i.div_done) begin
            cmd_q.start <= 1'b1;
            cmd_q.op    <= bvm_pkg::OP_FILT_STEP2;
            state_q     <= ST_FILT2;
          end
        end
        ST_FILT2: begin
          if (sts_i.div_done) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          // The raw sample is only converted when the battery is connecting.
          if (sts_i.need_cells) begin
            cmd_q.mul     <= 1'b1;
            cmd_q.mul_raw <= 1'b1;
            state_q       <= ST_MUL_RAW;
          end else begin
            state_q <= ST_WRITE;
          end
        end
        ST_MUL_RAW: begin
          cmd_q.start <= 1'b1;
          cmd_q.op    <= bvm_pkg::OP_RAW_STEP1;
          state_q     <= ST_RAW1;
        end
        ST_RAW1: begin
          if (sts_i.div_done) begin
            cmd_q.start <= 1'b1;
            cmd_q.op    <= bvm_pkg::OP_RAW_STEP2;
            state_q     <= ST_RAW2;
          end
        end
        ST_RAW2: begin
          if (sts_i.div_done) begin
            cmd_q.start <= 1'b1;
            cmd_q.op    <= bvm_pkg::OP_CELLS;
            state_q     <= ST_CELLS;
          end
        end
        ST_CELLS: begin
          if (sts_i.div_done) begin
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          // The result register is written only once the previous result has left it.
          if (!sts_i.out_busy) begin
            cmd_q.wb   <= 1'b1;
            in_ready_q <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o = in_ready_q;
  assign cmd_o      = cmd_q;

endmodule

`default_nettype wire

// ===== tb/tb_battery_voltage_monitor.sv =====
`timescale 1ns / 100ps

module tb_battery_voltage_monitor;

  localparam int MON_MAX_CELLS = 8;
  localparam int HYST          = 1;
  localparam int N_DIRECTED    = 22;
  localparam int N_SETTINGS    = 11;
  localparam int PHASE_SAMPLES = 100;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 200;

  typedef logic [bvm_pkg::SAMPLE_W-1:0]   sample_t;
  typedef logic [bvm_pkg::VOLT_W-1:0]     volt_t;
  typedef logic [bvm_pkg::SCALED_W-1:0]   scaled_t;
  typedef logic [bvm_pkg::CELLS_W-1:0]    cells_t;
  typedef logic [bvm_pkg::CELLV_W-1:0]    cellv_t;
  typedef logic [bvm_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [bvm_pkg::CFG_DATA_W-1:0] cfg_data_t;

  typedef struct packed {
    volt_t          voltage;
    scaled_t        scaled;
    bvm_pkg::mode_e status;
    bvm_pkg::beep_e beep;
    logic           failsafe;
    logic           arm;
    cells_t         cells;
  } reading_t;

  typedef struct packed {
    sample_t  filt;
    sample_t  raw;
    logic     typed;
    reading_t want;
  } stim_row_t;

  typedef struct packed {
    logic      pick_random;
    cfg_data_t scale;
    cfg_data_t div;
    cfg_data_t mult;
    cellv_t    max_cell;
    cellv_t    min_cell;
    cellv_t    warn_cell;
  } settings_t;

  // Reset defaults first, then a walk through a drop to warning and critical,
  // recovery, disconnection, the presence boundary and reconnection.
  localparam stim_row_t DIRECTED_ROWS[N_DIRECTED] = '{
    '{12'd0,    12'd0,    1'b1,
      '{16'd5, 9'd0, bvm_pkg::MODE_ABSENT, bvm_pkg::BEEP_NONE, 1'b0, 1'b0, 4'd1}},
    '{12'd4095, 12'd4095, 1'b1,
      '{16'd3778, 9'd330, bvm_pkg::MODE_OK, bvm_pkg::BEEP_NONE, 1'b0, 1'b0, 4'd8}},
    '{12'd290,  12'hAAA,  1'b0, '0},
    '{12'd290,  12'h555,  1'b0, '0},
    '{12'd270,  12'hFFF,  1'b0, '0},
    '{12'd270,  12'h000,  1'b0, '0},
    '{12'd300,  12'h0F0,  1'b0, '0},
    '{12'd320,  12'hF0F,  1'b0, '0},
    '{12'd0,    12'h123,  1'b1,
      '{16'd5, 9'd0, bvm_pkg::MODE_ABSENT, bvm_pkg::BEEP_NONE, 1'b0, 1'b0, 4'd0}},
    '{12'd6,    12'h800,  1'b0, '0},
    '{12'd7,    12'h000,  1'b0, '0},
    '{12'd7,    12'h000,  1'b0, '0},
    '{12'd20,   12'h7FF,  1'b0, '0},
    '{12'd40,   12'h001,  1'b0, '0},
    '{12'd40,   12'h002,  1'b0, '0},
    '{12'd6,    12'h3C3,  1'b0, '0},
    '{12'd4095, 12'h000,  1'b0, '0},
    '{12'd2048, 12'hFFF,  1'b0, '0},
    '{12'd1,    12'h001,  1'b0, '0},
    '{12'd4094, 12'hFFE,  1'b0, '0},
    '{12'd100,  12'h456,  1'b0, '0},
    '{12'd4095, 12'hFFF,  1'b0, '0}
  };

  // Zero divider, zero multiplier and zero full-cell voltage saturate on purpose.
  localparam settings_t SETTINGS_LIST[N_SETTINGS] = '{
    '{1'b0, 8'd110, 8'd10,  8'd1,   6'd43, 6'd33, 6'd35},
    '{1'b0, 8'd255, 8'd1,   8'd1,   6'd50, 6'd50, 6'd50},
    '{1'b0, 8'd1,   8'd255, 8'd255, 6'd1,  6'd1,  6'd1},
    '{1'b0, 8'd200, 8'd3,   8'd2,   6'd30, 6'd20, 6'd25},
    '{1'b0, 8'd110, 8'd0,   8'd1,   6'd43, 6'd33, 6'd35},
    '{1'b0, 8'd110, 8'd10,  8'd0,   6'd0,  6'd33, 6'd35},
    '{1'b0, 8'd255, 8'd255, 8'd1,   6'd50, 6'd1,  6'd50},
    '{1'b0, 8'd60,  8'd4,   8'd3,   6'd42, 6'd35, 6'd33},
    '{1'b1, 8'd0,   8'd0,   8'd0,   6'd0,  6'd0,  6'd0},
    '{1'b1, 8'd0,   8'd0,   8'd0,   6'd0,  6'd0,  6'd0},
    '{1'b0, 8'd110, 8'd10,  8'd1,   6'd43, 6'd33, 6'd35}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  bvm_in_if  in_if ();
  bvm_cfg_if cfg_if ();
  bvm_out_if out_if ();

  battery_voltage_monitor i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state and its copy of the configuration.
  bvm_pkg::mode_e mon_mode;
  cells_t         mon_cells;
  volt_t          mon_warn_level;
  volt_t          mon_crit_level;
  cfg_data_t      cfg_scale, cfg_div, cfg_mult;
  cellv_t         cfg_max_cell, cfg_min_cell, cfg_warn_cell;

  reading_t    expected_readings[$];
  int          mismatches;
  int unsigned samples_sent;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_cycles;
  logic        rx_hold;
  sample_t     last_filt;

  function automatic volt_t adc_to_decivolts(input sample_t s);
    longint unsigned num, q;
    if (cfg_div == 0 || cfg_mult == 0) return '1;
    num = longint'(s) * longint'(cfg_scale) * longint'(bvm_pkg::VOLT_K)
          + longint'(bvm_pkg::ROUND_ADD);
    q = num / (longint'(bvm_pkg::ADC_FULL) * longint'(cfg_div));
    q = q / longint'(cfg_mult);
    return (q > 65535) ? '1 : q[bvm_pkg::VOLT_W-1:0];
  endfunction

  function automatic reading_t predict_reading(input sample_t filt, input sample_t raw);
    reading_t r;
    volt_t volts;
    int sv, wl, cl, cnt;
    r = '0;
    volts = adc_to_decivolts(filt);
    r.voltage = volts;
    r.scaled = scaled_t'(int'(filt) * int'(bvm_pkg::SCALED_K) / int'(bvm_pkg::ADC_FULL));
    if (mon_mode == bvm_pkg::MODE_ABSENT && volts > bvm_pkg::PRESENT_LEVEL) begin
      mon_mode = bvm_pkg::MODE_OK;
      if (cfg_max_cell == 0) begin
        cnt = MON_MAX_CELLS;
      end else begin
        cnt = int'(adc_to_decivolts(raw)) / int'(cfg_max_cell) + 1;
      end
      if (cnt > MON_MAX_CELLS) cnt = MON_MAX_CELLS;
      mon_cells = cnt[bvm_pkg::CELLS_W-1:0];
      mon_warn_level = volt_t'(mon_cells) * volt_t'(cfg_warn_cell);
      mon_crit_level = volt_t'(mon_cells) * volt_t'(cfg_min_cell);
    end else if (mon_mode != bvm_pkg::MODE_ABSENT && volts <= bvm_pkg::PRESENT_LEVEL) begin
      mon_mode = bvm_pkg::MODE_ABSENT;
      mon_cells = '0;
      mon_warn_level = '0;
      mon_crit_level = '0;
    end
    sv = int'(volts);
    wl = int'(mon_warn_level);
    cl = int'(mon_crit_level);
    unique case (mon_mode)
      bvm_pkg::MODE_OK: begin
        if (sv <= wl - HYST) begin
          mon_mode = bvm_pkg::MODE_WARN;
          r.beep = bvm_pkg::BEEP_LOW;
        end
      end
      bvm_pkg::MODE_WARN: begin
        r.arm = 1'b1;
        if (sv <= cl - HYST) begin
          mon_mode = bvm_pkg::MODE_CRIT;
          r.beep = bvm_pkg::BEEP_CRIT;
        end else if (sv > wl + HYST) begin
          mon_mode = bvm_pkg::MODE_OK;
        end else begin
          r.beep = bvm_pkg::BEEP_LOW;
        end
        r.failsafe = 1'b1;
      end
      bvm_pkg::MODE_CRIT: begin
        if (sv > cl + HYST) begin
          mon_mode = bvm_pkg::MODE_WARN;
          r.beep = bvm_pkg::BEEP_LOW;
        end else begin
          r.beep = bvm_pkg::BEEP_CRIT;
        end
        r.failsafe = 1'b1;
      end
      default: ;
    endcase
    r.status = mon_mode;
    r.cells = mon_cells;
    return r;
  endfunction

  // Rough inverse of the conversion, so random samples land around a threshold.
  function automatic sample_t sample_near_level(input volt_t level);
    longint est;
    if (cfg_scale == 0) return sample_t'($urandom);
    est = longint'(level) * longint'(bvm_pkg::ADC_FULL) * longint'(cfg_div)
          * longint'(cfg_mult) / (longint'(cfg_scale) * longint'(bvm_pkg::VOLT_K));
    est = est + longint'($urandom_range(16)) - 8;
    if (est < 0) est = 0;
    if (est > longint'(bvm_pkg::ADC_FULL)) est = bvm_pkg::ADC_FULL;
    return est[bvm_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic send_sample(input sample_t filt, input sample_t raw,
                             input logic typed, input reading_t typed_want);
    reading_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.filtered_sample <= filt;
    in_if.raw_sample      <= raw;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predicted = predict_reading(filt, raw);
    expected_readings.push_back(typed ? typed_want : predicted);
    samples_sent++;
    last_filt = filt;
    @(negedge clk_i);
  endtask

  task automatic send_random_sample();
    sample_t filt, raw;
    int unsigned pick;
    int walk;
    pick = $urandom_range(99);
    if (mon_mode != bvm_pkg::MODE_ABSENT && pick < 35) begin
      filt = sample_near_level(mon_warn_level);
    end else if (mon_mode != bvm_pkg::MODE_ABSENT && pick < 60) begin
      filt = sample_near_level(mon_crit_level);
    end else if (pick < 80) begin
      walk = int'(last_filt) + int'($urandom_range(48)) - 24;
      if (walk < 0) walk = 0;
      if (walk > int'(bvm_pkg::ADC_FULL)) walk = bvm_pkg::ADC_FULL;
      filt = walk[bvm_pkg::SAMPLE_W-1:0];
    end else if (pick < 88) begin
      filt = sample_t'($urandom_range(15));
    end else if (pick < 96) begin
      filt = sample_t'($urandom);
    end else begin
      filt = $urandom_range(1) ? '1 : '0;
    end
    raw = ($urandom_range(99) < 80) ? sample_t'($urandom) : sample_t'($urandom_range(400));
    send_sample(filt, raw, 1'b0, '0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    unique case (idx)
      bvm_pkg::REG_VOLTAGE_SCALE:      cfg_scale     = data;
      bvm_pkg::REG_DIVIDER_VALUE:      cfg_div       = data;
      bvm_pkg::REG_DIVIDER_MULTIPLIER: cfg_mult      = data;
      bvm_pkg::REG_MAX_CELL_VOLTAGE:   cfg_max_cell  = data[bvm_pkg::CELLV_W-1:0];
      bvm_pkg::REG_MIN_CELL_VOLTAGE:   cfg_min_cell  = data[bvm_pkg::CELLV_W-1:0];
      bvm_pkg::REG_WARN_CELL_VOLTAGE:  cfg_warn_cell = data[bvm_pkg::CELLV_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic check_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin : check_reading
      reading_t want;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with nothing pending, voltage %0d", $realtime, out_if.voltage);
        end
      end else begin
        want = expected_readings.pop_front();
        check_field("voltage", want.voltage, out_if.voltage);
        check_field("scaled_value", want.scaled, out_if.scaled_value);
        check_field("battery_status", want.status, out_if.battery_status);
        check_field("beep_request", want.beep, out_if.beep_request);
        check_field("failsafe_request", want.failsafe, out_if.failsafe_request);
        check_field("arming_release", want.arm, out_if.arming_release);
        check_field("cells", want.cells, out_if.cells);
      end
    end
  end

  // Result side: random stalls, plus one long hold-off that backs up the input.
  always @(negedge clk_i) begin
    out_if.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    rx_hold = 1'b0;
    wait (samples_sent >= 150);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    settings_t s;
    in_if.valid           = 1'b0;
    in_if.filtered_sample = '0;
    in_if.raw_sample      = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = '0;
    cfg_if.data           = '0;
    out_if.ready          = 1'b0;
    rst_ni                = 1'b0;
    mismatches            = 0;
    samples_sent          = 0;
    stall_cycles          = 0;
    last_filt             = '0;
    send_idle_pct         = 15;
    recv_idle_pct         = 54;
    cfg_scale             = bvm_pkg::RST_VOLTAGE_SCALE;
    cfg_div               = bvm_pkg::RST_DIVIDER_VALUE;
    cfg_mult              = bvm_pkg::RST_DIVIDER_MULTIPLIER;
    cfg_max_cell          = bvm_pkg::RST_MAX_CELL_VOLTAGE;
    cfg_min_cell          = bvm_pkg::RST_MIN_CELL_VOLTAGE;
    cfg_warn_cell         = bvm_pkg::RST_WARN_CELL_VOLTAGE;
    mon_mode              = bvm_pkg::MODE_ABSENT;
    mon_cells             = bvm_pkg::RST_CELL_COUNT;
    mon_warn_level        = '0;
    mon_crit_level        = '0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_sample(DIRECTED_ROWS[i].filt, DIRECTED_ROWS[i].raw, DIRECTED_ROWS[i].typed,
                  DIRECTED_ROWS[i].want);
    end

    for (int p = 0; p < N_SETTINGS; p++) begin
      // Registers change only once the block has delivered everything it owes.
      in_if.valid <= 1'b0;
      while (expected_readings.size() != 0) @(negedge clk_i);
      s = SETTINGS_LIST[p];
      if (s.pick_random) begin
        s.scale     = $urandom_range(255);
        s.div       = $urandom_range(255, 1);
        s.mult      = $urandom_range(4, 1);
        s.max_cell  = $urandom_range(50, 1);
        s.min_cell  = $urandom_range(50, 1);
        s.warn_cell = $urandom_range(50, 1);
      end
      write_reg(bvm_pkg::REG_VOLTAGE_SCALE, s.scale);
      write_reg(bvm_pkg::REG_DIVIDER_VALUE, s.div);
      write_reg(bvm_pkg::REG_DIVIDER_MULTIPLIER, s.mult);
      write_reg(bvm_pkg::REG_MAX_CELL_VOLTAGE, cfg_data_t'(s.max_cell));
      write_reg(bvm_pkg::REG_MIN_CELL_VOLTAGE, cfg_data_t'(s.min_cell));
      write_reg(bvm_pkg::REG_WARN_CELL_VOLTAGE, cfg_data_t'(s.warn_cell));
      cfg_if.valid <= 1'b0;
      if (p < 4) begin
        send_idle_pct = 15;
        recv_idle_pct = 54;
      end else if (p < 8) begin
        send_idle_pct = 54;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < PHASE_SAMPLES; n++) send_random_sample();
    end

    in_if.valid <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bvm_pkg.sv
hw/rtl/bvm_in_if.sv
hw/rtl/bvm_out_if.sv
hw/rtl/bvm_cfg_if.sv
hw/rtl/bvm_div.sv
hw/rtl/bvm_dp.sv
hw/rtl/bvm_ctrl.sv
hw/rtl/battery_voltage_monitor.sv
tb/tb_battery_voltage_monitor.sv
